// ----- sv/sprite_screen_projection_core_macros.svh -----
// Assertion helpers shared by the projection core RTL.
`ifndef SPRITE_SCREEN_PROJECTION_CORE_MACROS_SVH
`define SPRITE_SCREEN_PROJECTION_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define SSPC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define SSPC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sspc_pkg.sv -----
package sspc_pkg;

    localparam int SCREEN_WIDTH_DEF  = 640;
    localparam int SCREEN_HEIGHT_DEF = 480;
    localparam int WIDTH_DIV_DEF     = 1;
    localparam int HEIGHT_DIV_DEF    = 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PLAYER_X        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLAYER_Y        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_PLANE_X     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_PLANE_Y     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VERTICAL_OFFSET = 3'd6;

    // camera-space division: |num| << 14 over |det|
    localparam int NUM1_W = 47;
    localparam int DEN1_W = 32;
    // saturating divisions deliver 12 quotient bits plus an overflow flag
    localparam int QS_W   = 12;
    localparam int SHN_W  = 21;

    typedef struct packed {
        logic signed [15:0] sprite_x;
        logic signed [15:0] sprite_y;
    } sprite_in_t;

    typedef struct packed {
        logic               visible;
        logic signed [15:0] depth;
        logic signed [11:0] screen_col;
        logic signed [11:0] shift_rows;
        logic        [11:0] proj_width;
        logic        [11:0] proj_height;
        logic        [10:0] left_col;
        logic signed [11:0] right_col;
        logic        [10:0] top_row;
        logic signed [11:0] bottom_row;
    } proj_out_t;

endpackage

// ----- sv/sspc_stream_if.sv -----
interface sspc_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/sprite_screen_projection_core.sv -----
// Sprite screen projection core.
// sprite_in carries one sprite world position (Q8.8) per transfer; proj_out
// carries one projection result per transfer: visible, depth, centre column,
// vertical shift, projected size and the clamped drawing rectangle.
// Camera registers are written through cfg_we/cfg_index/cfg_data, one per
// cycle, and unknown indexes are dropped; the user must write them only
// while no sprite is in flight, which the block itself does not enforce.
// Throughput: one sprite per cycle while proj_out is not stalled. Register
// ranks: 48 for the camera-space divide (operand load plus 47 quotient
// bits), 13 for the saturating column/shift/size divides (load plus 12
// quotient bits) and five more around the bit-serial pipelined dividers.
// Reset: camera registers return to their defaults (facing -x, plane 0.66
// on y) and every valid bit in the pipeline clears.
// Stall: the whole pipeline freezes while proj_out holds a result that is
// not taken; sprite_in.ready drops in the same cycle and nothing is lost.
// A sprite behind the camera or at zero depth, or a camera whose matrix is
// singular, yields a result with every field zero.
`include "sprite_screen_projection_core_macros.svh"

module sprite_screen_projection_core #(
    parameter int SCREEN_WIDTH  = sspc_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = sspc_pkg::SCREEN_HEIGHT_DEF,
    parameter int WIDTH_DIV     = sspc_pkg::WIDTH_DIV_DEF,
    parameter int HEIGHT_DIV    = sspc_pkg::HEIGHT_DIV_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sspc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sspc_pkg::CFG_DATA_W-1:0]  cfg_data,
    sspc_stream_if.sink                      sprite_in,
    sspc_stream_if.source                    proj_out
);
    localparam int Q1_W    = sspc_pkg::NUM1_W;
    localparam int QS_W    = sspc_pkg::QS_W;
    localparam int HALF_W  = SCREEN_WIDTH / 2;
    localparam int HALF_H  = SCREEN_HEIGHT / 2;
    localparam int HW_W    = $clog2(HALF_W + 1);
    localparam int CNUM_W  = Q1_W + HW_W;
    localparam int WDEN_W  = Q1_W + $clog2(WIDTH_DIV + 1);
    localparam int HDEN_W  = Q1_W + $clog2(HEIGHT_DIV + 1);
    localparam int PNUM    = SCREEN_HEIGHT * 256;
    localparam int PNUM_W  = $clog2(PNUM + 1);

    localparam logic signed [13:0] HALF_W14 = 14'(HALF_W);
    localparam logic signed [13:0] HALF_H14 = 14'(HALF_H);
    localparam logic signed [13:0] RMAX14   = 14'(SCREEN_WIDTH - 1);
    localparam logic signed [13:0] BMAX14   = 14'(SCREEN_HEIGHT - 1);
    localparam logic signed [13:0] MIN12    = -14'sd2048;
    localparam logic signed [13:0] MAX12    = 14'sd2047;
    localparam logic signed [13:0] MAX11    = 14'sd2047;
    localparam logic signed [13:0] ZERO14   = 14'sd0;
    localparam logic [Q1_W-1:0]    DEPTH_MAX = Q1_W'(32767);

    function automatic logic signed [13:0] clamp14(input logic signed [13:0] v,
                                                   input logic signed [13:0] lo,
                                                   input logic signed [13:0] hi);
        logic signed [13:0] r;
        r = v;
        if (v < lo)
            r = lo;
        else if (v > hi)
            r = hi;
        return r;
    endfunction

    // ---------------- camera registers ----------------
    logic signed [15:0] player_x_reg, player_y_reg;
    logic signed [15:0] view_dir_x_reg, view_dir_y_reg;
    logic signed [15:0] cam_plane_x_reg, cam_plane_y_reg;
    logic signed [12:0] vertical_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            player_x_reg        <= '0;
            player_y_reg        <= '0;
            view_dir_x_reg      <= -16'sd16384;
            view_dir_y_reg      <= '0;
            cam_plane_x_reg     <= '0;
            cam_plane_y_reg     <= 16'sd10813;
            vertical_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sspc_pkg::REG_PLAYER_X:        player_x_reg        <= cfg_data;
                sspc_pkg::REG_PLAYER_Y:        player_y_reg        <= cfg_data;
                sspc_pkg::REG_VIEW_DIR_X:      view_dir_x_reg      <= cfg_data;
                sspc_pkg::REG_VIEW_DIR_Y:      view_dir_y_reg      <= cfg_data;
                sspc_pkg::REG_CAM_PLANE_X:     cam_plane_x_reg     <= cfg_data;
                sspc_pkg::REG_CAM_PLANE_Y:     cam_plane_y_reg     <= cfg_data;
                sspc_pkg::REG_VERTICAL_OFFSET: vertical_offset_reg <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Global advance: every stage moves unless a finished result is stuck.
    logic adv;
    logic out_valid_reg;
    sspc_pkg::proj_out_t out_data_reg;

    assign adv             = !out_valid_reg || proj_out.ready;
    assign sprite_in.ready = adv;

    // ---------------- stage 1: offsets and determinant ----------------
    logic               s1_valid_reg;
    logic signed [16:0] dx_reg, dy_reg, dx_next, dy_next;
    logic signed [32:0] det1_reg, det1_next;

    always_comb
    begin
        dx_next   = 17'(sprite_in.data.sprite_x) - 17'(player_x_reg);
        dy_next   = 17'(sprite_in.data.sprite_y) - 17'(player_y_reg);
        det1_next = 33'(cam_plane_x_reg * view_dir_y_reg)
                  - 33'(view_dir_x_reg * cam_plane_y_reg);
    end

    // ---------------- stage 2: inverse-matrix numerators ----------------
    logic               s2_valid_reg;
    logic signed [33:0] numx_reg, numy_reg, numx_next, numy_next;
    logic signed [32:0] det2_reg;

    always_comb
    begin
        numx_next = 34'(view_dir_y_reg * dx_reg) - 34'(view_dir_x_reg * dy_reg);
        numy_next = 34'(cam_plane_x_reg * dy_reg) - 34'(cam_plane_y_reg * dx_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= sprite_in.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            det1_reg <= det1_next;
            numx_reg <= numx_next;
            numy_reg <= numy_next;
            det2_reg <= det1_reg;
        end
    end

    // Sign-magnitude split feeding the camera-space dividers.
    logic [33:0]        numx_abs, numy_abs;
    logic [32:0]        det_abs;
    logic [Q1_W-1:0]    num1x, num1y;
    logic               sgn_x;
    logic [1:0]         side_y;

    always_comb
    begin
        numx_abs = numx_reg[33] ? 34'(-numx_reg) : 34'(numx_reg);
        numy_abs = numy_reg[33] ? 34'(-numy_reg) : 34'(numy_reg);
        det_abs  = det2_reg[32] ? 33'(-det2_reg) : 33'(det2_reg);
        num1x    = {numx_abs[32:0], 14'b0};
        num1y    = {numy_abs[32:0], 14'b0};
        sgn_x    = numx_reg[33] ^ det2_reg[32];
        side_y   = {det2_reg == '0, numy_reg[33] ^ det2_reg[32]};
    end

    logic            vx, vy;
    logic [Q1_W-1:0] qx, qy;
    logic            sx_d;
    logic [1:0]      sy_d;

    sspc_div #(.NW(Q1_W), .DW(sspc_pkg::DEN1_W), .QW(Q1_W), .SW(1)) u_div_tx (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(s2_valid_reg),
        .num(num1x), .den(det_abs[31:0]), .side_in(sgn_x),
        .out_valid(vx), .quo(qx), .ovf(), .rem_nz(), .side_out(sx_d)
    );

    sspc_div #(.NW(Q1_W), .DW(sspc_pkg::DEN1_W), .QW(Q1_W), .SW(2)) u_div_ty (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(s2_valid_reg),
        .num(num1y), .den(det_abs[31:0]), .side_in(side_y),
        .out_valid(vy), .quo(qy), .ovf(), .rem_nz(), .side_out(sy_d)
    );

    // ---------------- stage 4: screen-space numerators ----------------
    logic               s4_valid_reg;
    logic [CNUM_W-1:0]  colnum_reg, colnum_next;
    logic               col_neg_reg;
    logic [Q1_W-1:0]    ty_reg;
    logic [12:0]        vo_abs;
    logic [sspc_pkg::SHN_W-1:0] shnum_reg, shnum_next;
    logic               sh_neg_reg;
    logic [WDEN_W-1:0]  wden_reg, wden_next;
    logic [HDEN_W-1:0]  hden_reg, hden_next;
    logic [15:0]        depth_reg, depth_next;
    logic               bad_reg, bad_next;

    always_comb
    begin
        colnum_next = CNUM_W'(qx) * CNUM_W'(HALF_W);
        vo_abs      = vertical_offset_reg[12] ? 13'(-vertical_offset_reg)
                                              : 13'(vertical_offset_reg);
        shnum_next  = {vo_abs, 8'b0};
        wden_next   = WDEN_W'(qy) * WDEN_W'(WIDTH_DIV);
        hden_next   = HDEN_W'(qy) * HDEN_W'(HEIGHT_DIV);
        depth_next  = (qy > DEPTH_MAX) ? 16'(DEPTH_MAX) : qy[15:0];
        // singular camera, negative depth or depth truncated to zero
        bad_next    = sy_d[1] | sy_d[0] | (qy == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (adv)
            s4_valid_reg <= vx & vy;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            colnum_reg  <= colnum_next;
            col_neg_reg <= sx_d;
            ty_reg      <= qy;
            shnum_reg   <= shnum_next;
            sh_neg_reg  <= vertical_offset_reg[12];
            wden_reg    <= wden_next;
            hden_reg    <= hden_next;
            depth_reg   <= depth_next;
            bad_reg     <= bad_next;
        end
    end

    // Four saturating dividers in lockstep.
    logic            vc, vs, vw, vh;
    logic [QS_W-1:0] qc, qs, qw, qh;
    logic            oc, os, ow, oh, rc;
    logic            neg_c, neg_s, bad_d;
    logic [15:0]     depth_d;

    sspc_div #(.NW(CNUM_W), .DW(Q1_W), .QW(QS_W), .SW(1)) u_div_col (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(s4_valid_reg),
        .num(colnum_reg), .den(ty_reg), .side_in(col_neg_reg),
        .out_valid(vc), .quo(qc), .ovf(oc), .rem_nz(rc), .side_out(neg_c)
    );

    sspc_div #(.NW(sspc_pkg::SHN_W), .DW(Q1_W), .QW(QS_W), .SW(1)) u_div_shift (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(s4_valid_reg),
        .num(shnum_reg), .den(ty_reg), .side_in(sh_neg_reg),
        .out_valid(vs), .quo(qs), .ovf(os), .rem_nz(), .side_out(neg_s)
    );

    sspc_div #(.NW(PNUM_W), .DW(WDEN_W), .QW(QS_W), .SW(16)) u_div_wid (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(s4_valid_reg),
        .num(PNUM_W'(PNUM)), .den(wden_reg), .side_in(depth_reg),
        .out_valid(vw), .quo(qw), .ovf(ow), .rem_nz(), .side_out(depth_d)
    );

    sspc_div #(.NW(PNUM_W), .DW(HDEN_W), .QW(QS_W), .SW(1)) u_div_hgt (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(s4_valid_reg),
        .num(PNUM_W'(PNUM)), .den(hden_reg), .side_in(bad_reg),
        .out_valid(vh), .quo(qh), .ovf(oh), .rem_nz(), .side_out(bad_d)
    );

    // ---------------- stage 5: saturate column, shift and size ----------------
    logic               s5_valid_reg;
    logic signed [11:0] col_reg, col_next, shift_reg, shift_next;
    logic [11:0]        wid_reg, wid_next, hgt_reg, hgt_next;
    logic [15:0]        depth5_reg;
    logic               bad5_reg;
    logic signed [13:0] cq, sq, col_pos, col_neg, col_fix;

    always_comb
    begin
        cq      = signed'({2'b00, qc});
        sq      = signed'({2'b00, qs});
        col_pos = HALF_W14 + cq;
        col_neg = HALF_W14 - cq;
        // a negative offset that leaves the column positive rounds down, not up
        col_fix = col_neg - ((rc && (col_neg > ZERO14)) ? 14'sd1 : 14'sd0);
        if (oc)
            col_next = neg_c ? 12'(MIN12) : 12'(MAX12);
        else if (!neg_c)
            col_next = 12'(clamp14(col_pos, MIN12, MAX12));
        else
            col_next = 12'(clamp14(col_fix, MIN12, MAX12));

        if (os)
            shift_next = neg_s ? 12'(MIN12) : 12'(MAX12);
        else
            shift_next = 12'(clamp14(neg_s ? -sq : sq, MIN12, MAX12));

        wid_next = ow ? 12'hfff : qw;
        hgt_next = oh ? 12'hfff : qh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (adv)
            s5_valid_reg <= vc & vs & vw & vh;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            col_reg    <= col_next;
            shift_reg  <= shift_next;
            wid_reg    <= wid_next;
            hgt_reg    <= hgt_next;
            depth5_reg <= depth_d;
            bad5_reg   <= bad_d;
        end
    end

    // ---------------- stage 6: drawing rectangle, output register ----------------
    sspc_pkg::proj_out_t out_data_next;
    logic signed [13:0]  col14, sh14, w2, h2;

    always_comb
    begin
        col14 = 14'(col_reg);
        sh14  = 14'(shift_reg);
        w2    = signed'({3'b000, wid_reg[11:1]});
        h2    = signed'({3'b000, hgt_reg[11:1]});

        out_data_next             = '0;
        out_data_next.visible     = 1'b1;
        out_data_next.depth       = depth5_reg;
        out_data_next.screen_col  = col_reg;
        out_data_next.shift_rows  = shift_reg;
        out_data_next.proj_width  = wid_reg;
        out_data_next.proj_height = hgt_reg;
        out_data_next.left_col    = 11'(clamp14(col14 - w2, ZERO14, MAX11));
        out_data_next.right_col   = 12'(clamp14(col14 + w2, MIN12, RMAX14));
        out_data_next.top_row     = 11'(clamp14(HALF_H14 + sh14 - h2, ZERO14, MAX11));
        out_data_next.bottom_row  = 12'(clamp14(HALF_H14 + sh14 + h2, MIN12, BMAX14));
        // hidden sprite: drop everything to zero
        if (bad5_reg)
            out_data_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= out_data_next;
    end

    assign proj_out.valid = out_valid_reg;
    assign proj_out.data  = out_data_reg;

    // ---------------- assertions ----------------
    `SSPC_ASSERT_IMP(a_hidden_zero, proj_out.valid && !proj_out.data.visible, proj_out.data.depth == '0 && proj_out.data.proj_width == '0 && proj_out.data.screen_col == '0 && proj_out.data.bottom_row == '0, "hidden sprite carries nonzero fields")
    `SSPC_ASSERT_IMP(a_visible_depth, proj_out.valid && proj_out.data.visible, proj_out.data.depth > 16'sd0, "visible sprite without positive depth")
    `SSPC_ASSERT_NXT(a_stall_freeze, !adv, $stable(s1_valid_reg) && $stable(s4_valid_reg) && $stable(s5_valid_reg), "pipeline moved while output stalled")

endmodule

// ----- sv/sspc_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage.
// With QW < NW the quotient must stay below 2**QW; otherwise ovf is raised.
module sspc_div #(
    parameter int NW = 47,
    parameter int DW = 32,
    parameter int QW = 47,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic          ovf,
    output logic          rem_nz,
    output logic [SW-1:0] side_out
);
    localparam int HW = (NW > QW) ? NW - QW : 1;
    localparam int CW = (HW > DW) ? HW : DW;

    logic [QW:0]   valid_reg;
    logic [DW-1:0] rem_reg  [QW+1];
    logic [QW-1:0] lo_reg   [QW+1];
    logic [DW-1:0] den_reg  [QW+1];
    logic [SW-1:0] side_reg [QW+1];
    logic          ovf_reg  [QW+1];

    logic [DW-1:0] rem_next [QW+1];
    logic [QW-1:0] lo_next  [QW+1];
    logic          ovf_next;

    generate
        if (NW > QW) begin : g_hi
            logic [HW-1:0] hi;
            assign hi          = num[NW-1:QW];
            assign ovf_next    = CW'(hi) >= CW'(den);
            assign rem_next[0] = DW'(hi);
        end else begin : g_nohi
            assign ovf_next    = 1'b0;
            assign rem_next[0] = '0;
        end
    endgenerate
    assign lo_next[0] = num[QW-1:0];

    genvar k;
    generate
        for (k = 1; k <= QW; k++) begin : g_stage
            logic [DW:0] trial;
            logic        ge;
            assign trial = {rem_reg[k-1], lo_reg[k-1][QW-1]};
            assign ge    = trial >= {1'b0, den_reg[k-1]};
            assign rem_next[k] = ge ? DW'(trial - {1'b0, den_reg[k-1]}) : trial[DW-1:0];
            assign lo_next[k]  = {lo_reg[k-1][QW-2:0], ge};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next[k];
                    lo_reg[k]   <= lo_next[k];
                    den_reg[k]  <= den_reg[k-1];
                    side_reg[k] <= side_reg[k-1];
                    ovf_reg[k]  <= ovf_reg[k-1];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem_next[0];
            lo_reg[0]   <= lo_next[0];
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
            ovf_reg[0]  <= ovf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[QW-1:0], in_valid};
    end

    assign out_valid = valid_reg[QW];
    assign quo       = lo_reg[QW];
    assign ovf       = ovf_reg[QW];
    assign rem_nz    = |rem_reg[QW];
    assign side_out  = side_reg[QW];
endmodule

// ----- sim/tb_sprite_screen_projection_core.sv -----
module tb_sprite_screen_projection_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCR_W = sspc_pkg::SCREEN_WIDTH_DEF;
    localparam int SCR_H = sspc_pkg::SCREEN_HEIGHT_DEF;
    localparam int W_DIV = sspc_pkg::WIDTH_DIV_DEF;
    localparam int H_DIV = sspc_pkg::HEIGHT_DIV_DEF;
    // extra wait used by drain, scaled with NUM1_W
    localparam int PIPE_LAT = 18 + sspc_pkg::NUM1_W;
    // index past the end of the register list
    localparam logic [sspc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [sspc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [sspc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    sspc_stream_if #(.payload_t(sspc_pkg::sprite_in_t)) sprite_in ();
    sspc_stream_if #(.payload_t(sspc_pkg::proj_out_t)) proj_out ();

    sprite_screen_projection_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .sprite_in(sprite_in.sink), .proj_out(proj_out.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Camera copy kept by the testbench, updated alongside every register write.
    logic signed [15:0] cam_px = 16'sd0, cam_py = 16'sd0, cam_dx = -16'sd16384;
    logic signed [15:0] cam_dy = 16'sd0;
    logic signed [15:0] cam_lx = 16'sd0, cam_ly = 16'sd10813;
    logic signed [12:0] cam_voff = 13'sd0;

    sspc_pkg::sprite_in_t pending_sprites[$];
    sspc_pkg::proj_out_t  expected_proj[$];
    int error_count = 0;
    int result_count = 0;
    int visible_count = 0;
    bit calm = 1'b0;       // set for the closing stretch: no idling either side
    int src_gap = 0;
    int snk_gap = 0;

    function automatic longint clamp64(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Project one sprite through the current camera copy.
    function automatic sspc_pkg::proj_out_t project_sprite(sspc_pkg::sprite_in_t s);
        sspc_pkg::proj_out_t r;
        longint dx, dy, det, tx, ty, col, shf, wid, hgt, hh;
        r = '0;
        dx = longint'(s.sprite_x) - longint'(cam_px);
        dy = longint'(s.sprite_y) - longint'(cam_py);
        det = longint'(cam_lx) * longint'(cam_dy) - longint'(cam_dx) * longint'(cam_ly);
        if (det == 0)
            return r;
        tx = (longint'(cam_dy) * dx - longint'(cam_dx) * dy) * 16384 / det;
        ty = (longint'(cam_lx) * dy - longint'(cam_ly) * dx) * 16384 / det;
        if (ty <= 0)
            return r;
        col = clamp64(longint'(SCR_W / 2) * (ty + tx) / ty, -64'sd2048, 64'sd2047);
        shf = clamp64(longint'(cam_voff) * 256 / ty, -64'sd2048, 64'sd2047);
        wid = clamp64(longint'(SCR_H) * 256 / (ty * W_DIV), 64'sd0, 64'sd4095);
        hgt = clamp64(longint'(SCR_H) * 256 / (ty * H_DIV), 64'sd0, 64'sd4095);
        hh = longint'(SCR_H / 2);
        r.visible = 1'b1;
        r.depth = 16'(clamp64(ty, -64'sd32768, 64'sd32767));
        r.screen_col = 12'(col);
        r.shift_rows = 12'(shf);
        r.proj_width = 12'(wid);
        r.proj_height = 12'(hgt);
        r.left_col = 11'(clamp64(col - wid / 2, 64'sd0, 64'sd2047));
        r.right_col = 12'(clamp64(col + wid / 2, -64'sd2048, longint'(SCR_W - 1)));
        r.top_row = 11'(clamp64(hh + shf - hgt / 2, 64'sd0, 64'sd2047));
        r.bottom_row = 12'(clamp64(hh + shf + hgt / 2, -64'sd2048, longint'(SCR_H - 1)));
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Driver: present queued sprites, with random idle bursts on the source side.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sprite_in.valid <= 1'b0;
            sprite_in.data <= '0;
        end
        else
        begin
            // the transfer that just happened retires the head entry
            if (sprite_in.valid && sprite_in.ready)
            begin
                expected_proj.push_back(project_sprite(pending_sprites.pop_front()));
            end
            if (!(sprite_in.valid && !sprite_in.ready))
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    sprite_in.valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 9) == 0)
                begin
                    src_gap = int'($urandom_range(0, 4));
                    sprite_in.valid <= 1'b0;
                end
                else if (pending_sprites.size() > 0)
                begin
                    sprite_in.valid <= 1'b1;
                    sprite_in.data <= pending_sprites[0];
                end
                else
                    sprite_in.valid <= 1'b0;
            end
        end
    end

    // Monitor: check every result transfer and toggle sink-side stalls.
    always @(posedge clk or negedge rst_n)
    begin
        sspc_pkg::proj_out_t got, want;
        if (!rst_n)
            proj_out.ready <= 1'b0;
        else
        begin
            if (proj_out.valid && proj_out.ready)
            begin
                got = proj_out.data;
                result_count++;
                if (expected_proj.size() == 0)
                begin
                    report_mismatch("unexpected result", 64'sd1, 64'sd0);
                end
                else
                begin
                    want = expected_proj.pop_front();
                    if (want.visible) visible_count++;
                    if (got.visible !== want.visible)
                        report_mismatch("visible", longint'(got.visible),
                                        longint'(want.visible));
                    if (got.depth !== want.depth)
                        report_mismatch("depth", longint'(got.depth), longint'(want.depth));
                    if (got.screen_col !== want.screen_col)
                        report_mismatch("screen_col", longint'(got.screen_col),
                                        longint'(want.screen_col));
                    if (got.shift_rows !== want.shift_rows)
                        report_mismatch("shift_rows", longint'(got.shift_rows),
                                        longint'(want.shift_rows));
                    if (got.proj_width !== want.proj_width)
                        report_mismatch("proj_width", longint'(got.proj_width),
                                        longint'(want.proj_width));
                    if (got.proj_height !== want.proj_height)
                        report_mismatch("proj_height", longint'(got.proj_height),
                                        longint'(want.proj_height));
                    if (got.left_col !== want.left_col)
                        report_mismatch("left_col", longint'(got.left_col),
                                        longint'(want.left_col));
                    if (got.right_col !== want.right_col)
                        report_mismatch("right_col", longint'(got.right_col),
                                        longint'(want.right_col));
                    if (got.top_row !== want.top_row)
                        report_mismatch("top_row", longint'(got.top_row),
                                        longint'(want.top_row));
                    if (got.bottom_row !== want.bottom_row)
                        report_mismatch("bottom_row", longint'(got.bottom_row),
                                        longint'(want.bottom_row));
                end
            end
            if (snk_gap > 0)
            begin
                snk_gap--;
                proj_out.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                snk_gap = int'($urandom_range(0, 4));
                proj_out.ready <= 1'b0;
            end
            else
                proj_out.ready <= 1'b1;
        end
    end

    // Write one camera register while the core is idle; mirror it locally.
    task automatic write_reg(logic [sspc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            sspc_pkg::REG_PLAYER_X: cam_px = val;
            sspc_pkg::REG_PLAYER_Y: cam_py = val;
            sspc_pkg::REG_VIEW_DIR_X: cam_dx = val;
            sspc_pkg::REG_VIEW_DIR_Y: cam_dy = val;
            sspc_pkg::REG_CAM_PLANE_X: cam_lx = val;
            sspc_pkg::REG_CAM_PLANE_Y: cam_ly = val;
            sspc_pkg::REG_VERTICAL_OFFSET: cam_voff = val[12:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_camera(logic [15:0] px, logic [15:0] py, logic [15:0] dxv,
                              logic [15:0] dyv, logic [15:0] lxv, logic [15:0] lyv,
                              logic [15:0] voff);
        write_reg(sspc_pkg::REG_PLAYER_X, px);
        write_reg(sspc_pkg::REG_PLAYER_Y, py);
        write_reg(sspc_pkg::REG_VIEW_DIR_X, dxv);
        write_reg(sspc_pkg::REG_VIEW_DIR_Y, dyv);
        write_reg(sspc_pkg::REG_CAM_PLANE_X, lxv);
        write_reg(sspc_pkg::REG_CAM_PLANE_Y, lyv);
        write_reg(sspc_pkg::REG_VERTICAL_OFFSET, voff);
    endtask

    // Hold until the core has drained everything queued so far.
    task automatic drain;
        while (pending_sprites.size() > 0 || sprite_in.valid || expected_proj.size() > 0)
            @(posedge clk);
        repeat (PIPE_LAT + 5) @(posedge clk);
    endtask

    function automatic sspc_pkg::sprite_in_t mk(int x, int y);
        sspc_pkg::sprite_in_t s;
        s.sprite_x = 16'(x);
        s.sprite_y = 16'(y);
        return s;
    endfunction

    // Small signed offset around zero, drawn from 0..span-1 and centered.
    function automatic int rnd_off(int span);
        return int'($urandom_range(0, span - 1)) - span / 2;
    endfunction

    // Sprites near the player mostly, so that many land on screen.
    task automatic random_batch(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                pending_sprites.push_back(mk(int'($urandom), int'($urandom)));
            else
                pending_sprites.push_back(mk(int'(cam_px) + rnd_off(8192),
                                             int'(cam_py) + rnd_off(8192)));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset camera, field extremes, behind-camera, zero depth.
        pending_sprites.push_back(mk(0, 0));
        pending_sprites.push_back(mk(-256, 0));
        pending_sprites.push_back(mk(-512, 128));
        pending_sprites.push_back(mk(-1, 0));
        pending_sprites.push_back(mk(256, 0));
        pending_sprites.push_back(mk(-32768, -32768));
        pending_sprites.push_back(mk(-32768, 32767));
        pending_sprites.push_back(mk(32767, 32767));
        pending_sprites.push_back(mk(-3, 3000));
        pending_sprites.push_back(mk(-100, -32768));
        drain();

        // Singular camera: every result is zero.
        set_camera(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        pending_sprites.push_back(mk(-256, 0));
        pending_sprites.push_back(mk(1000, -1000));
        drain();

        // Extreme registers, including index beyond the list.
        set_camera(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h1000);
        write_reg(REG_UNUSED, 16'hffff);
        pending_sprites.push_back(mk(32767, -32768));
        pending_sprites.push_back(mk(-32768, 32767));
        pending_sprites.push_back(mk(0, 0));
        drain();
        set_camera(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h0fff);
        pending_sprites.push_back(mk(-32768, 32767));
        pending_sprites.push_back(mk(32767, -32768));
        drain();

        // Random phases over a range of cameras.
        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph == 0)
                set_camera(16'd0, 16'd0, -16'sd16384, 16'd0, 16'd0, 16'd10813, 16'h0fff);
            else if (ph == 1)
                set_camera(16'd1000, -16'sd2000, 16'd0, 16'd16384, 16'd10813, 16'd0, 16'h1000);
            else if ($urandom_range(0, 2) == 0)
                set_camera(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom), 16'($urandom));
            else
                set_camera(16'(rnd_off(8192)), 16'(rnd_off(8192)),
                           16'(rnd_off(32768)), 16'(rnd_off(32768)),
                           16'(rnd_off(32768)), 16'(rnd_off(32768)),
                           16'($urandom));
            if (ph == 9)
                calm = 1'b1;
            random_batch(103);
            drain();
        end

        $display("Covered %0d projections (%0d visible) across directed and random cameras.",
                 result_count, visible_count);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/sspc_pkg.sv
sv/sspc_stream_if.sv
sv/sspc_div.sv
sv/sprite_screen_projection_core.sv
sim/tb_sprite_screen_projection_core.sv
